// ===== rtl/core/rcdd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RC differential-drive mixer: widths, constants, codes,
// controller states and the command/status structs. No dependencies.
package rcdd_pkg;

    localparam int COUNT_W     = 20;
    localparam int PCT_W       = 8;
    localparam int SPEED_W     = 7;
    localparam int LEVEL_W     = 16;
    localparam int MODE_W      = 2;
    localparam int DZ_W        = 7;
    localparam int WRAP_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Shared multiplier: 23 x 24 bits into a 47-bit product register
    localparam int MUL_X_W = 23;
    localparam int MUL_Y_W = 24;
    localparam int PROD_W  = MUL_X_W + MUL_Y_W;
    localparam int OFFS_W  = 16;

    // Counts below COUNT_LOW saturate low, at or above COUNT_HIGH saturate high
    localparam logic [COUNT_W-1:0] COUNT_LOW  = COUNT_W'(62500);
    localparam logic [COUNT_W-1:0] COUNT_HIGH = COUNT_W'(125625);

    // floor(x/625) = (x * RECIP625) >> 26 for x < 63125
    localparam logic [MUL_Y_W-1:0] RECIP625       = MUL_Y_W'(107375);
    localparam int                 RECIP625_SHIFT = 26;
    // floor(x/100) = (x * RECIP100) >> 30 for x < 2^23
    localparam logic [MUL_Y_W-1:0] RECIP100       = MUL_Y_W'(10737419);
    localparam int                 RECIP100_SHIFT = 30;

    localparam logic [SPEED_W-1:0] PCT_MAX = SPEED_W'(100);

    // Square root of a 14-bit radicand, two bits per step
    localparam int SQRT_STEPS = 7;
    localparam int SQRT_RAD_W = 2 * SQRT_STEPS;
    localparam int SQRT_REM_W = SPEED_W + 2;
    localparam int SQRT_ACC_W = SQRT_REM_W + 2;
    localparam int SQRT_CNT_W = 3;

    localparam logic [DZ_W-1:0]   DEADZONE_RST = DZ_W'(7);
    localparam logic [WRAP_W-1:0] PWM_WRAP_RST = WRAP_W'(12500);

    typedef enum logic [MODE_W-1:0] {
        MIX_NONE,
        MIX_LINEAR,
        MIX_SQRT,
        MIX_SQUARE
    } mix_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIX_MODE,
        CFG_DEADZONE,
        CFG_PWM_WRAP
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_CONV_S,
        MUL_CONV_T,
        MUL_SQUARE,
        MUL_RECIP100,
        MUL_LVL_L,
        MUL_LVL_R
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV_S,
        ST_CONV_T,
        ST_SQ_MUL,
        ST_SQ_DIV,
        ST_SQRT,
        ST_MIX,
        ST_LVL_L_MUL,
        ST_LVL_L_DIV,
        ST_LVL_R_MUL,
        ST_LVL_R_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     wr_steer;
        logic     wr_throttle;
        logic     wr_square;
        logic     sqrt_start;
        logic     sqrt_step;
        logic     wr_mix;
        logic     wr_level_l;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_last;
    } dp_stat_t;

endpackage

// ===== rtl/core/rcdd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the mixer: control tick in, drive result out.
// Depends on rcdd_pkg for field widths.
interface rcdd_tick_if;
    logic                            valid;
    logic                            ready;
    logic [rcdd_pkg::COUNT_W-1:0]    steer_count;
    logic [rcdd_pkg::COUNT_W-1:0]    throttle_count;

    modport source (output valid, output steer_count, output throttle_count, input ready);
    modport sink   (input valid, input steer_count, input throttle_count, output ready);
endinterface

interface rcdd_drive_if;
    logic                            valid;
    logic                            ready;
    logic [rcdd_pkg::LEVEL_W-1:0]    left_level;
    logic [rcdd_pkg::LEVEL_W-1:0]    right_level;
    logic [rcdd_pkg::SPEED_W-1:0]    left_speed;
    logic [rcdd_pkg::SPEED_W-1:0]    right_speed;
    logic                            left_forward;
    logic                            right_forward;

    modport source (output valid, output left_level, output right_level,
                    output left_speed, output right_speed,
                    output left_forward, output right_forward, input ready);
    modport sink   (input valid, input left_level, input right_level,
                    input left_speed, input right_speed,
                    input left_forward, input right_forward, output ready);
endinterface

// ===== rtl/core/rcdd_ctrl.sv =====
`timescale 1ns / 1ps
// Mixer controller: sequences one item through the datapath and owns the
// input ready and output valid. Depends on rcdd_pkg.
module rcdd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output rcdd_pkg::dp_cmd_t  cmd,
    input  rcdd_pkg::dp_stat_t stat
);
    import rcdd_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CONV_S;
                end
            end
            ST_CONV_S:
            begin
                cmd.mul_sel = MUL_CONV_S;
                state_next  = ST_CONV_T;
            end
            ST_CONV_T:
            begin
                cmd.mul_sel  = MUL_CONV_T;
                cmd.wr_steer = 1'b1;
                state_next   = ST_SQ_MUL;
            end
            ST_SQ_MUL:
            begin
                cmd.wr_throttle = 1'b1;
                cmd.mul_sel     = MUL_SQUARE;
                cmd.sqrt_start  = 1'b1;
                state_next      = ST_SQ_DIV;
            end
            ST_SQ_DIV:
            begin
                cmd.mul_sel = MUL_RECIP100;
                state_next  = ST_SQRT;
            end
            ST_SQRT:
            begin
                // product holds a*a/100 throughout; write it while the root runs
                cmd.wr_square = 1'b1;
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                cmd.wr_mix = 1'b1;
                state_next = ST_LVL_L_MUL;
            end
            ST_LVL_L_MUL:
            begin
                cmd.mul_sel = MUL_LVL_L;
                state_next  = ST_LVL_L_DIV;
            end
            ST_LVL_L_DIV:
            begin
                cmd.mul_sel = MUL_RECIP100;
                state_next  = ST_LVL_R_MUL;
            end
            ST_LVL_R_MUL:
            begin
                cmd.wr_level_l = 1'b1;
                cmd.mul_sel    = MUL_LVL_R;
                state_next     = ST_LVL_R_DIV;
            end
            ST_LVL_R_DIV:
            begin
                cmd.mul_sel = MUL_RECIP100;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free or drains this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an item not yet taken");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CONV_S && !in_ready))
        else $error("accepted item did not start conversion");

    a_sqrt_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT && stat.sqrt_last) |=> (state_reg == ST_MIX))
        else $error("square root did not hand over to mixing");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output valid rose outside the final state");

endmodule

// ===== rtl/core/rcdd_datapath.sv =====
`timescale 1ns / 1ps
// Mixer datapath: configuration registers, count conversion, shared
// multiplier, digit-by-digit square root, mixing and output register.
// Depends on rcdd_pkg.
module rcdd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rcdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rcdd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [rcdd_pkg::COUNT_W-1:0]      steer_count,
    input  logic [rcdd_pkg::COUNT_W-1:0]      throttle_count,
    input  rcdd_pkg::dp_cmd_t                 cmd,
    output rcdd_pkg::dp_stat_t                stat,
    output logic [rcdd_pkg::LEVEL_W-1:0]      left_level,
    output logic [rcdd_pkg::LEVEL_W-1:0]      right_level,
    output logic [rcdd_pkg::SPEED_W-1:0]      left_speed,
    output logic [rcdd_pkg::SPEED_W-1:0]      right_speed,
    output logic                              left_forward,
    output logic                              right_forward
);
    import rcdd_pkg::*;

    // Configuration
    mix_mode_t          mix_mode_reg;
    logic [DZ_W-1:0]    deadzone_reg;
    logic [WRAP_W-1:0]  pwm_wrap_reg;

    // Item state
    logic [COUNT_W-1:0]       steer_count_reg, throttle_count_reg;
    logic signed [PCT_W-1:0]  steer_value_reg, throttle_value_reg;
    logic                     left_dir_reg, right_dir_reg;
    logic                     left_dir_next, right_dir_next;
    logic [PROD_W-1:0]        prod_reg;
    logic [SPEED_W-1:0]       square_reg;
    logic [SPEED_W-1:0]       ls_reg, rs_reg, ls_next, rs_next;
    logic [LEVEL_W-1:0]       level_l_reg;

    // Square root
    logic [SQRT_RAD_W-1:0]    rad_reg;
    logic [SQRT_REM_W-1:0]    rem_reg;
    logic [SPEED_W-1:0]       root_reg;
    logic [SQRT_CNT_W-1:0]    cnt_reg;

    // Output register
    logic [LEVEL_W-1:0]       left_level_reg, right_level_reg;
    logic [SPEED_W-1:0]       left_speed_reg, right_speed_reg;
    logic                     left_fwd_reg, right_fwd_reg;

    logic [COUNT_W-1:0]       steer_diff, throttle_diff;
    logic [MUL_X_W-1:0]       mul_x;
    logic [MUL_Y_W-1:0]       mul_y;
    logic [PROD_W-1:0]        prod_next;
    logic [SPEED_W-1:0]       conv_q;
    logic signed [PCT_W-1:0]  steer_neg, throttle_neg;
    logic [SPEED_W-1:0]       steer_mag, thr_mag;
    logic [WRAP_W-1:0]        wrap_top;
    logic [SQRT_RAD_W-1:0]    rad_init;
    logic [SQRT_ACC_W-1:0]    sq_acc, sq_trial, sq_diff;
    logic [SPEED_W-1:0]       shaped, inner, ls_raw, rs_raw;

    function automatic logic signed [PCT_W-1:0] conv_pct(
        input logic [COUNT_W-1:0]      c,
        input logic [SPEED_W-1:0]      q,
        input logic signed [PCT_W-1:0] last
    );
        logic signed [PCT_W:0]   w;
        logic signed [PCT_W-1:0] v;
        begin
            w = $signed({1'b0, q, 1'b0}) - $signed((PCT_W+1)'(100));
            if (c == '0)
                v = last;
            else if (c < COUNT_LOW)
                v = -$signed(PCT_W'(100));
            else if (c >= COUNT_HIGH)
                v = $signed(PCT_W'(100));
            else
                v = w[PCT_W-1:0];
            return v;
        end
    endfunction

    function automatic logic [SPEED_W-1:0] finish_speed(
        input logic [SPEED_W-1:0] s,
        input logic [DZ_W-1:0]    dz
    );
        logic [SPEED_W-1:0] r;
        begin
            r = (s > PCT_MAX) ? PCT_MAX : s;
            if (DZ_W'(r) < dz)
                r = '0;
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_mode_reg <= MIX_SQUARE;
            deadzone_reg <= DEADZONE_RST;
            pwm_wrap_reg <= PWM_WRAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIX_MODE: mix_mode_reg <= mix_mode_t'(cfg_wdata[MODE_W-1:0]);
                CFG_DEADZONE: deadzone_reg <= cfg_wdata[DZ_W-1:0];
                CFG_PWM_WRAP: pwm_wrap_reg <= cfg_wdata[WRAP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Offsets into the unsaturated count range, only meaningful inside it
    assign steer_diff    = steer_count_reg - COUNT_LOW;
    assign throttle_diff = throttle_count_reg - COUNT_LOW;
    assign conv_q        = prod_reg[RECIP625_SHIFT +: SPEED_W];

    assign steer_neg    = -steer_value_reg;
    assign throttle_neg = -throttle_value_reg;
    assign steer_mag    = steer_value_reg[PCT_W-1] ? steer_neg[SPEED_W-1:0]
                                                   : steer_value_reg[SPEED_W-1:0];
    assign thr_mag      = throttle_value_reg[PCT_W-1] ? throttle_neg[SPEED_W-1:0]
                                                      : throttle_value_reg[SPEED_W-1:0];
    assign wrap_top     = (pwm_wrap_reg == '0) ? '0 : pwm_wrap_reg - WRAP_W'(1);

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (cmd.mul_sel)
            MUL_CONV_S:
            begin
                mul_x = MUL_X_W'(steer_diff[OFFS_W-1:0]);
                mul_y = RECIP625;
            end
            MUL_CONV_T:
            begin
                mul_x = MUL_X_W'(throttle_diff[OFFS_W-1:0]);
                mul_y = RECIP625;
            end
            MUL_SQUARE:
            begin
                mul_x = MUL_X_W'(steer_mag);
                mul_y = MUL_Y_W'(steer_mag);
            end
            MUL_RECIP100:
            begin
                mul_x = prod_reg[MUL_X_W-1:0];
                mul_y = RECIP100;
            end
            MUL_LVL_L:
            begin
                mul_x = MUL_X_W'(wrap_top);
                mul_y = MUL_Y_W'(ls_reg);
            end
            MUL_LVL_R:
            begin
                mul_x = MUL_X_W'(wrap_top);
                mul_y = MUL_Y_W'(rs_reg);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_x) * PROD_W'(mul_y);

    // 100*a as shifts and adds
    assign rad_init = (SQRT_RAD_W'(steer_mag) << 6) + (SQRT_RAD_W'(steer_mag) << 5)
                    + (SQRT_RAD_W'(steer_mag) << 2);
    assign sq_acc   = {rem_reg, rad_reg[SQRT_RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_diff  = sq_acc - sq_trial;
    assign stat.sqrt_last = (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1));

    always_comb
    begin
        case (mix_mode_reg)
            MIX_LINEAR: shaped = steer_mag;
            MIX_SQRT:   shaped = root_reg;
            MIX_SQUARE: shaped = square_reg;
            default:    shaped = steer_mag;
        endcase
        inner = (thr_mag > shaped) ? thr_mag - shaped : '0;

        if (mix_mode_reg == MIX_NONE)
        begin
            ls_raw = thr_mag;
            rs_raw = thr_mag;
        end
        else if (thr_mag == '0)
        begin
            // spin in place
            ls_raw = steer_mag;
            rs_raw = steer_mag;
        end
        else
        begin
            ls_raw = steer_value_reg < 0 ? inner : thr_mag;
            rs_raw = steer_value_reg > 0 ? inner : thr_mag;
        end

        left_dir_next  = left_dir_reg;
        right_dir_next = right_dir_reg;
        if (throttle_value_reg == 0)
        begin
            if (steer_value_reg < 0)
            begin
                left_dir_next  = 1'b0;
                right_dir_next = 1'b1;
            end
            else if (steer_value_reg > 0)
            begin
                left_dir_next  = 1'b1;
                right_dir_next = 1'b0;
            end
        end
        else
        begin
            left_dir_next  = !throttle_value_reg[PCT_W-1];
            right_dir_next = !throttle_value_reg[PCT_W-1];
        end

        ls_next = finish_speed(ls_raw, deadzone_reg);
        rs_next = finish_speed(rs_raw, deadzone_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_value_reg    <= '0;
            throttle_value_reg <= '0;
            left_dir_reg       <= 1'b1;
            right_dir_reg      <= 1'b1;
            cnt_reg            <= '0;
        end
        else
        begin
            if (cmd.wr_steer)
                steer_value_reg <= conv_pct(steer_count_reg, conv_q, steer_value_reg);
            if (cmd.wr_throttle)
                throttle_value_reg <= conv_pct(throttle_count_reg, conv_q,
                                               throttle_value_reg);
            if (cmd.wr_mix)
            begin
                left_dir_reg  <= left_dir_next;
                right_dir_reg <= right_dir_next;
            end
            if (cmd.sqrt_start)
                cnt_reg <= '0;
            else if (cmd.sqrt_step)
                cnt_reg <= cnt_reg + SQRT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            steer_count_reg    <= steer_count;
            throttle_count_reg <= throttle_count;
        end
        if (cmd.mul_sel != MUL_NONE)
            prod_reg <= prod_next;
        if (cmd.wr_square)
            square_reg <= prod_reg[RECIP100_SHIFT +: SPEED_W];
        if (cmd.sqrt_start)
        begin
            rad_reg  <= rad_init;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= rad_reg << 2;
            if (sq_acc >= sq_trial)
            begin
                rem_reg  <= sq_diff[SQRT_REM_W-1:0];
                root_reg <= {root_reg[SPEED_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= sq_acc[SQRT_REM_W-1:0];
                root_reg <= {root_reg[SPEED_W-2:0], 1'b0};
            end
        end
        if (cmd.wr_mix)
        begin
            ls_reg <= ls_next;
            rs_reg <= rs_next;
        end
        if (cmd.wr_level_l)
            level_l_reg <= prod_reg[RECIP100_SHIFT +: LEVEL_W];
        if (cmd.load_out)
        begin
            left_level_reg  <= level_l_reg;
            right_level_reg <= prod_reg[RECIP100_SHIFT +: LEVEL_W];
            left_speed_reg  <= ls_reg;
            right_speed_reg <= rs_reg;
            left_fwd_reg    <= left_dir_reg;
            right_fwd_reg   <= right_dir_reg;
        end
    end

    assign left_level    = left_level_reg;
    assign right_level   = right_level_reg;
    assign left_speed    = left_speed_reg;
    assign right_speed   = right_speed_reg;
    assign left_forward  = left_fwd_reg;
    assign right_forward = right_fwd_reg;

endmodule

// ===== rtl/core/rc_differential_drive_mixer_core.sv =====
`timescale 1ns / 1ps
// RC differential-drive mixer, top level. Depends on rcdd_pkg, rcdd_if,
// rcdd_ctrl and rcdd_datapath.
// The sequencer takes one item at a time and accepts the next only after
// loading the result; it runs the shared multiplier and the 7-step square
// root for each item, and a full output register can stall it at the end.
// A new item is taken while the previous result still waits in the output
// register. Reset is asynchronous, active low; no clearing pass.
module rc_differential_drive_mixer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rcdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rcdd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    rcdd_tick_if.sink                         tick,
    rcdd_drive_if.source                      drive
);
    import rcdd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rcdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_valid (drive.valid),
        .out_ready (drive.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rcdd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .steer_count    (tick.steer_count),
        .throttle_count (tick.throttle_count),
        .cmd            (cmd),
        .stat           (stat),
        .left_level     (drive.left_level),
        .right_level    (drive.right_level),
        .left_speed     (drive.left_speed),
        .right_speed    (drive.right_speed),
        .left_forward   (drive.left_forward),
        .right_forward  (drive.right_forward)
    );

endmodule

// ===== verif/rc_differential_drive_mixer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rc_differential_drive_mixer_core: directed and random
// control ticks against an in-bench mixer model. Depends on rcdd_pkg and rcdd_if.
module rc_differential_drive_mixer_core_tb;
    import rcdd_pkg::*;

    localparam int LATENCY   = 17;
    localparam int RUN_LIMIT = 400_000;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 120;

    typedef struct packed {
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] right_level;
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
        logic               left_forward;
        logic               right_forward;
    } drive_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    rcdd_tick_if  tick_ch ();
    rcdd_drive_if drive_ch ();

    rc_differential_drive_mixer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick      (tick_ch),
        .drive     (drive_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mixer model state and register copies
    mix_mode_t                 cur_mode;
    logic [DZ_W-1:0]           cur_deadzone;
    logic [WRAP_W-1:0]         cur_wrap;
    logic signed [PCT_W-1:0]   held_steer;
    logic signed [PCT_W-1:0]   held_throttle;
    logic                      left_fwd;
    logic                      right_fwd;

    drive_result_t expected_drive[$];
    int            mismatch_count = 0;
    int            results_seen   = 0;
    int unsigned   cycle_count    = 0;
    int            ready_hold     = 0;
    bit            no_idle        = 1'b0;

    function automatic logic signed [PCT_W-1:0] to_percent(input logic [COUNT_W-1:0] count,
                                                            input logic signed [PCT_W-1:0] held);
        int v;
        if (count == '0)
            return held;
        v = 2 * int'(count / 625) - 300;
        if (v > 100)
            v = 100;
        if (v < -100)
            v = -100;
        return PCT_W'(v);
    endfunction

    function automatic int trim_speed(input int s);
        if (s > 100)
            s = 100;
        if (s < int'(cur_deadzone))
            s = 0;
        return s;
    endfunction

    function automatic logic [LEVEL_W-1:0] drive_level(input int speed);
        int unsigned top;
        top = (cur_wrap == '0) ? 0 : int'(cur_wrap) - 1;
        return LEVEL_W'((top * speed) / 100);
    endfunction

    // Advance the model by one tick and return the drive it produces
    function automatic drive_result_t mix_drive(input logic [COUNT_W-1:0] steer,
                                                input logic [COUNT_W-1:0] throttle);
        drive_result_t res;
        int sv;
        int tv;
        int a;
        int t;
        int shaped;
        int inner;
        int ls;
        int rs;
        held_steer    = to_percent(steer, held_steer);
        held_throttle = to_percent(throttle, held_throttle);
        sv = held_steer;
        tv = held_throttle;
        a  = (sv < 0) ? -sv : sv;
        t  = (tv < 0) ? -tv : tv;

        if (cur_mode == MIX_NONE)
        begin
            ls = t;
            rs = t;
        end
        else if (t == 0)
        begin
            ls = a;
            rs = a;
        end
        else
        begin
            case (cur_mode)
                MIX_LINEAR:
                    shaped = a;
                MIX_SQRT:
                begin
                    shaped = 0;
                    while ((shaped + 1) * (shaped + 1) <= 100 * a)
                        shaped++;
                end
                default:
                    shaped = (a * a) / 100;
            endcase
            inner = (t > shaped) ? t - shaped : 0;
            ls = (sv < 0) ? inner : t;
            rs = (sv > 0) ? inner : t;
        end

        // Zero throttle with zero steer keeps the last directions
        if (tv == 0)
        begin
            if (sv < 0)
            begin
                left_fwd  = 1'b0;
                right_fwd = 1'b1;
            end
            if (sv > 0)
            begin
                left_fwd  = 1'b1;
                right_fwd = 1'b0;
            end
        end
        else
        begin
            left_fwd  = (tv > 0);
            right_fwd = (tv > 0);
        end

        ls = trim_speed(ls);
        rs = trim_speed(rs);
        res.left_level    = drive_level(ls);
        res.right_level   = drive_level(rs);
        res.left_speed    = SPEED_W'(ls);
        res.right_speed   = SPEED_W'(rs);
        res.left_forward  = left_fwd;
        res.right_forward = right_fwd;
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COUNT_W'($urandom_range(0, 1048575));
            2:
            begin
                case ($urandom_range(0, 7))
                    0: return COUNT_W'(1);
                    1: return COUNT_W'(62499);
                    2: return COUNT_W'(62500);
                    3: return COUNT_W'(93750);
                    4: return COUNT_W'(125624);
                    5: return COUNT_W'(125625);
                    6: return COUNT_W'(94374);
                    default: return COUNT_W'(1048575);
                endcase
            end
            default: return COUNT_W'($urandom_range(62000, 126300));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic compare_field(input string name, input logic [LEVEL_W-1:0] got,
                                 input logic [LEVEL_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Result checker
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n === 1'b1 && drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1)
        begin
            if (expected_drive.size() == 0)
                report_mismatch("result with no item pending");
            else
            begin
                want = expected_drive.pop_front();
                compare_field("left_level", drive_ch.left_level, want.left_level);
                compare_field("right_level", drive_ch.right_level, want.right_level);
                compare_field("left_speed", LEVEL_W'(drive_ch.left_speed), LEVEL_W'(want.left_speed));
                compare_field("right_speed", LEVEL_W'(drive_ch.right_speed),
                              LEVEL_W'(want.right_speed));
                compare_field("left_forward", LEVEL_W'(drive_ch.left_forward),
                              LEVEL_W'(want.left_forward));
                compare_field("right_forward", LEVEL_W'(drive_ch.right_forward),
                              LEVEL_W'(want.right_forward));
            end
            results_seen++;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            drive_ch.ready <= 1'b0;
            ready_hold     <= 0;
        end
        else if (ready_hold != 0)
        begin
            drive_ch.ready <= 1'b0;
            ready_hold     <= ready_hold - 1;
        end
        else
        begin
            drive_ch.ready <= 1'b1;
            ready_hold     <= idle_len();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("rc_differential_drive_mixer_core test failed");
            $finish;
        end
    end

    // Offer one item, hold until taken, then idle a random while
    task automatic send_tick(input logic [COUNT_W-1:0] steer, input logic [COUNT_W-1:0] throttle);
        int gap;
        tick_ch.valid          <= 1'b1;
        tick_ch.steer_count    <= steer;
        tick_ch.throttle_count <= throttle;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        expected_drive.push_back(mix_drive(steer, throttle));
        gap = idle_len();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_drive();
        tick_ch.valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_MIX_MODE: cur_mode     = mix_mode_t'(data[MODE_W-1:0]);
            CFG_DEADZONE: cur_deadzone = data[DZ_W-1:0];
            CFG_PWM_WRAP: cur_wrap     = data[WRAP_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only once the block has gone quiet
    task automatic configure(input mix_mode_t mode, input int dz, input int wrap);
        drain_drive();
        repeat (LATENCY + 3) @(posedge clk);
        write_reg(CFG_MIX_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_DEADZONE, CFG_DATA_W'(dz));
        write_reg(CFG_PWM_WRAP, CFG_DATA_W'(wrap));
    endtask

    task automatic test_reset_config();
        send_tick(20'd0, 20'd0);
        send_tick(20'd1, 20'hFFFFF);
        send_tick(20'hFFFFF, 20'd1);
        send_tick(20'd93750, 20'd0);
        send_tick(20'd62500, 20'd93750);
        send_tick(20'd93750, 20'd93750);
        send_tick(20'd125625, 20'd0);
        send_tick(20'd0, 20'd125624);
    endtask

    task automatic test_mix_modes();
        mix_mode_t m;
        for (int k = 0; k < 3; k++)
        begin
            m = (k == 0) ? MIX_LINEAR : (k == 1) ? MIX_SQRT : MIX_NONE;
            configure(m, 0, 12500);
            send_tick(20'd100000, 20'd110000);
            send_tick(20'd94375, 20'hFFFFF);
            send_tick(20'd87500, 20'd62500);
        end
    endtask

    task automatic test_deadzone_and_wrap();
        configure(MIX_SQUARE, 100, 0);
        send_tick(20'd93750, 20'hFFFFF);
        configure(MIX_SQUARE, 101, 1);
        send_tick(20'd93750, 20'hFFFFF);
        configure(MIX_LINEAR, 127, 65535);
        send_tick(20'd125625, 20'd62500);
        configure(MIX_SQUARE, 8, 65535);
        send_tick(20'd93750, 20'd96875);
        send_tick(20'd93750, 20'd95000);
    endtask

    task automatic test_random_traffic();
        int dz;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            no_idle = 1'b0;
            dz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
            case (phase)
                0: configure(MIX_NONE, 0, 65535);
                1: configure(MIX_LINEAR, 100, 1);
                2: configure(MIX_SQRT, $urandom_range(0, 20), $urandom_range(2, 65535));
                3: configure(MIX_SQUARE, 0, $urandom_range(1, 65535));
                default: configure(mix_mode_t'($urandom_range(0, 3)), dz, $urandom_range(0, 65535));
            endcase
            no_idle = (phase == 2);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                // Starve the block now and then until every result is out
                if (i == PHASE_LEN / 2 || $urandom_range(0, 39) == 0)
                    drain_drive();
                send_tick(pick_count(), pick_count());
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_MIX_MODE;
        cfg_wdata              <= '0;
        tick_ch.valid          <= 1'b0;
        tick_ch.steer_count    <= '0;
        tick_ch.throttle_count <= '0;
        cur_mode      = MIX_SQUARE;
        cur_deadzone  = DEADZONE_RST;
        cur_wrap      = PWM_WRAP_RST;
        held_steer    = '0;
        held_throttle = '0;
        left_fwd      = 1'b1;
        right_fwd     = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_mix_modes();
        test_deadzone_and_wrap();
        test_random_traffic();

        drain_drive();
        repeat (LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("rc_differential_drive_mixer_core test passed");
        else
            $display("rc_differential_drive_mixer_core test failed");
        $finish;
    end

endmodule
